[rtl/sfr_pkg.sv]
package sfr_pkg;

    // Byte position counter width; covers frame lengths up to 63 bytes.
    localparam int unsigned POS_W = 6;

    // Frame byte positions that carry the three speed words.
    localparam logic [POS_W-1:0] WORD_FIRST_POS = 6'd3;
    localparam logic [POS_W-1:0] WORD_LAST_POS  = 6'd14;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned LANES   = 4;

    // Configuration register indexes.
    localparam logic CFG_HEAD = 1'b0;
    localparam logic CFG_TAIL = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] ang_z_word;
        logic [WORD_W-1:0] lin_y_word;
        logic [WORD_W-1:0] lin_x_word;
    } frame_result_t;

endpackage

[rtl/sfr_parser.sv]
module sfr_parser #(
    parameter int unsigned FRAME_BYTES = 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [sfr_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [sfr_pkg::BYTE_W-1:0]  head_byte,
    input  logic [sfr_pkg::BYTE_W-1:0]  tail_byte,
    output sfr_pkg::frame_result_t      result
);
    import sfr_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] CHECK_POS = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] XOR_END   = POS_W'(FRAME_BYTES - 3);
    localparam logic [POS_W-1:0] FRAME_LEN = POS_W'(FRAME_BYTES);

    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [BYTE_W-1:0] xor_reg,   xor_next;
    logic [BYTE_W-1:0] check_reg, check_next;
    logic [WORD_W-1:0] x_reg,     x_next;
    logic [WORD_W-1:0] y_reg,     y_next;
    logic [WORD_W-1:0] z_reg,     z_next;
    logic              hunting;

    assign hunting = (pos_reg == '0) || (pos_reg >= FRAME_LEN);

    always_comb
    begin
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        check_next = check_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        result     = '0;
        if (step)
        begin
            if (hunting)
            begin
                pos_next = '0;
                if (rx_byte == head_byte)
                begin
                    pos_next   = POS_W'(1);
                    xor_next   = '0;
                    check_next = '0;
                    x_next     = '0;
                    y_next     = '0;
                    z_next     = '0;
                end
            end
            else
            begin
                if (pos_reg <= XOR_END)
                    xor_next = xor_reg ^ rx_byte;
                if (pos_reg == CHECK_POS)
                    check_next = rx_byte;
                // Little-endian lane capture into the three words.
                for (int k = 0; k < LANES; k++)
                begin
                    if (pos_reg == WORD_FIRST_POS + POS_W'(k))
                        x_next[k*BYTE_W +: BYTE_W] = rx_byte;
                    if (pos_reg == WORD_FIRST_POS + POS_W'(LANES + k))
                        y_next[k*BYTE_W +: BYTE_W] = rx_byte;
                    if (pos_reg == WORD_FIRST_POS + POS_W'(2*LANES + k))
                        z_next[k*BYTE_W +: BYTE_W] = rx_byte;
                end
                if (pos_reg == LAST_POS)
                begin
                    pos_next          = '0;
                    result.valid      = (rx_byte == tail_byte) && (xor_reg == check_reg);
                    result.lin_x_word = x_reg;
                    result.lin_y_word = y_reg;
                    result.ang_z_word = z_reg;
                end
                else
                    pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            xor_reg   <= '0;
            check_reg <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            check_reg <= check_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
        end
    end

endmodule

[rtl/sfr_out_reg.sv]
module sfr_out_reg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sfr_pkg::frame_result_t                result,
    input  logic                                  tready,
    output logic                                  busy,
    output logic                                  tvalid,
    output logic [3*sfr_pkg::WORD_W-1:0]          tdata
);
    import sfr_pkg::*;

    logic                  valid_reg, valid_next;
    logic [3*WORD_W-1:0]   data_reg,  data_next;

    // Holding a result nobody has taken yet stalls the parser.
    assign busy = valid_reg && !tready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (!busy)
        begin
            valid_next = result.valid;
            if (result.valid)
                data_next = {result.ang_z_word, result.lin_y_word, result.lin_x_word};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign tvalid = valid_reg;
    assign tdata  = data_reg;

endmodule

[rtl/serial_frame_receiver_bcc_top.sv]
// A word accepted on s_axis that completes a good frame drives m_axis through the input
// register, then the result register; a result waiting on m_axis can hold it between them.
// Throughput: one byte word per cycle while m_axis takes results; while a result waits
// on m_axis the parser holds, and only one more byte is taken into the input register.
// Reset (rst_n, async, active low): parser hunts for the head byte, head=123, tail=125.
module serial_frame_receiver_bcc_top #(
    parameter int unsigned FRAME_BYTES = 17   // 17..63
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,      // 0 head_byte, 1 tail_byte
    input  logic [7:0]  cfg_data,
    // Received bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Decoded speed words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // [31:0] lin_x_word, [63:32] lin_y_word,
                                        // [95:64] ang_z_word
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] head_reg, head_next;
    logic [BYTE_W-1:0] tail_reg, tail_next;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg,  in_byte_next;
    logic              out_busy;
    logic              step;
    frame_result_t     result;

    // Config registers: plain write, indexes past the list do not exist here.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEAD: head_next = cfg_data;
                CFG_TAIL: tail_next = cfg_data;
                default:  ;
            endcase
        end
    end

    // The byte held in the input register advances into the parser
    // unless the result register is still holding an untaken result.
    assign step          = in_valid_reg && !out_busy;
    assign s_axis_tready = !in_valid_reg || !out_busy;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
            if (s_axis_tvalid)
                in_byte_next = s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= 8'd123;
            tail_reg     <= 8'd125;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
    end

    sfr_parser #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .head_byte (head_reg),
        .tail_byte (tail_reg),
        .result    (result)
    );

    sfr_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .result (result),
        .tready (m_axis_tready),
        .busy   (out_busy),
        .tvalid (m_axis_tvalid),
        .tdata  (m_axis_tdata)
    );

endmodule
